>>> src/qwlt_pkg.sv
// Shared constants and helpers for the quoted word and line tokenizer.
// No dependencies.
package qwlt_pkg;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_BS = 8'h5C;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  localparam int TUSER_CHAR_VALID = 0;
  localparam int TUSER_WORD_DONE  = 1;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       word_done;
    logic       line_done;
  } qwlt_result_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) ||
               (b == 8'h0C) || (b == 8'h0D);
  endfunction

endpackage

>>> src/quoted_word_line_tokenizer.sv
// Shell-style tokenizer: splits a byte stream into words and lines.
// Depends on qwlt_pkg.
// The result of an input transfer is captured in the output register when the byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register
// is empty or is being drained in the same cycle.
// Bytes that give no result update the state only and leave no output transfer.
// Synchronous active-high reset clears the escape, quote and open-word state
// and empties the output register.
module quoted_word_line_tokenizer
  import qwlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] word_done
  output logic       m_axis_tlast    // line_done
);

  logic         escape_pending;
  logic         escape_pending_next;
  logic [1:0]   quote_mode;
  logic [1:0]   quote_mode_next;
  logic         word_open;
  logic         word_open_next;
  logic         has_result;
  qwlt_result_t res;
  qwlt_result_t result;
  logic         result_valid;
  logic         accept;

  assign s_axis_tready = !result_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    escape_pending_next = escape_pending;
    quote_mode_next     = quote_mode;
    word_open_next      = word_open;
    has_result          = 1'b0;
    res                 = '0;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      word_open_next      = 1'b1;
      has_result          = 1'b1;
      res.char_valid      = 1'b1;
      res.out_char        = s_axis_tdata;
    end else if (quote_mode == QM_SINGLE) begin
      if (s_axis_tdata == CH_SQ) begin
        quote_mode_next = QM_NONE;
      end else begin
        word_open_next = 1'b1;
        has_result     = 1'b1;
        res.char_valid = 1'b1;
        res.out_char   = s_axis_tdata;
      end
    end else if (quote_mode == QM_DOUBLE) begin
      if (s_axis_tdata == CH_DQ) begin
        quote_mode_next = QM_NONE;
      end else if (s_axis_tdata == CH_BS) begin
        escape_pending_next = 1'b1;
      end else begin
        word_open_next = 1'b1;
        has_result     = 1'b1;
        res.char_valid = 1'b1;
        res.out_char   = s_axis_tdata;
      end
    end else if (s_axis_tdata == CH_NL) begin
      word_open_next  = 1'b0;
      quote_mode_next = QM_NONE;
      has_result      = 1'b1;
      res.word_done   = word_open;
      res.line_done   = 1'b1;
    end else if (s_axis_tdata == CH_SQ) begin
      quote_mode_next = QM_SINGLE;
    end else if (s_axis_tdata == CH_DQ) begin
      quote_mode_next = QM_DOUBLE;
    end else if (s_axis_tdata == CH_BS) begin
      escape_pending_next = 1'b1;
    end else if (is_blank(s_axis_tdata)) begin
      if (word_open) begin
        word_open_next = 1'b0;
        has_result     = 1'b1;
        res.word_done  = 1'b1;
      end
    end else begin
      word_open_next = 1'b1;
      has_result     = 1'b1;
      res.char_valid = 1'b1;
      res.out_char   = s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      quote_mode     <= QM_NONE;
      word_open      <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        escape_pending <= escape_pending_next;
        quote_mode     <= quote_mode_next;
        word_open      <= word_open_next;
        result_valid   <= has_result;
      end else if (m_axis_tready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      result <= res;
    end
  end

  assign m_axis_tvalid                  = result_valid;
  assign m_axis_tdata                   = result.out_char;
  assign m_axis_tuser[TUSER_CHAR_VALID] = result.char_valid;
  assign m_axis_tuser[TUSER_WORD_DONE]  = result.word_done;
  assign m_axis_tlast                   = result.line_done;

`ifndef SYNTHESIS
  a_line_has_no_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[TUSER_CHAR_VALID])
    else $error("line end carries an appended byte");

  a_char_not_word_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[TUSER_CHAR_VALID] && m_axis_tuser[TUSER_WORD_DONE]))
    else $error("appended byte and word end in one transfer");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[TUSER_CHAR_VALID] |-> m_axis_tdata == 8'h00)
    else $error("out_char not zero without an appended byte");

  a_newline_closes: assert property (@(posedge clk) disable iff (rst)
    accept && !escape_pending && quote_mode == QM_NONE && s_axis_tdata == CH_NL
    |=> !word_open && m_axis_tvalid && m_axis_tlast)
    else $error("unquoted newline did not close the line");

  a_no_escape_in_single: assert property (@(posedge clk) disable iff (rst)
    !(escape_pending && quote_mode == QM_SINGLE))
    else $error("escape pending inside single quotes");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for quoted_word_line_tokenizer: byte streams in, token flags out.
// Tracks escape, quote and open-word state to predict each output transfer.
// Depends on qwlt_pkg and the tokenizer RTL.
module tb_top;
  import qwlt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 1720;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_AT        = 1550;

  class token_tracker;
    qwlt_result_t pending_tokens[$];
    logic         escaping;
    logic [1:0]   quoting;
    logic         in_word;
    int           errors;

    function new();
      escaping = 1'b0;
      quoting  = QM_NONE;
      in_word  = 1'b0;
      errors   = 0;
    endfunction

    function bit is_space(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
    endfunction

    function void note_byte(logic [7:0] b);
      qwlt_result_t tok;
      bit           add;
      bit           emit;
      tok  = '0;
      add  = 1'b0;
      emit = 1'b0;
      if (escaping) begin
        add = 1'b1;
      end else if (quoting == QM_SINGLE) begin
        if (b == CH_SQ) quoting = QM_NONE;
        else add = 1'b1;
      end else if (quoting == QM_DOUBLE) begin
        if (b == CH_DQ) quoting = QM_NONE;
        else if (b == CH_BS) escaping = 1'b1;
        else add = 1'b1;
      end else if (b == CH_NL) begin
        tok.word_done = in_word;
        tok.line_done = 1'b1;
        in_word = 1'b0;
        quoting = QM_NONE;
        emit = 1'b1;
      end else if (b == CH_SQ) begin
        quoting = QM_SINGLE;
      end else if (b == CH_DQ) begin
        quoting = QM_DOUBLE;
      end else if (b == CH_BS) begin
        escaping = 1'b1;
      end else if (is_space(b)) begin
        if (in_word) begin
          tok.word_done = 1'b1;
          in_word = 1'b0;
          emit = 1'b1;
        end
      end else begin
        add = 1'b1;
      end
      if (add) begin
        escaping = 1'b0;
        in_word = 1'b1;
        tok.char_valid = 1'b1;
        tok.out_char = b;
        emit = 1'b1;
      end
      if (emit) pending_tokens = {pending_tokens, tok};
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_token(logic [7:0] data, logic [1:0] user, logic last);
      qwlt_result_t want;
      if (pending_tokens.size() == 0) begin
        report_mismatch("output transfer with no token expected");
        return;
      end
      want = pending_tokens.pop_front();
      if (user[TUSER_CHAR_VALID] !== want.char_valid)
        report_mismatch($sformatf("char_valid %0b, expected %0b",
                                  user[TUSER_CHAR_VALID], want.char_valid));
      if (data !== want.out_char)
        report_mismatch($sformatf("out_char %02h, expected %02h", data, want.out_char));
      if (user[TUSER_WORD_DONE] !== want.word_done)
        report_mismatch($sformatf("word_done %0b, expected %0b",
                                  user[TUSER_WORD_DONE], want.word_done));
      if (last !== want.line_done)
        report_mismatch($sformatf("line_done %0b, expected %0b", last, want.line_done));
    endtask

    function int outstanding();
      return pending_tokens.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  token_tracker tracker = new();
  int           bytes_sent = 0;
  bit           calm = 1'b0;
  int           idle_cycles = 0;

  quoted_word_line_tokenizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic idle_input(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 8'($urandom_range(8'h7A, 8'h61));
    if (roll < 55) begin
      case ($urandom_range(4))
        0: return 8'h20;
        1: return 8'h09;
        2: return 8'h0B;
        3: return 8'h0C;
        default: return 8'h0D;
      endcase
    end
    if (roll < 62) return CH_NL;
    if (roll < 68) return CH_SQ;
    if (roll < 76) return CH_DQ;
    if (roll < 83) return CH_BS;
    return 8'($urandom_range(255));
  endfunction

  initial begin : stimulus
    logic [7:0] opening_bytes[$];
    int         gap_pct;
    opening_bytes = '{8'h20, 8'h00, 8'h09, 8'hFF, CH_NL, CH_NL, CH_SQ, CH_SQ, CH_DQ, CH_DQ,
                      8'h0B, CH_SQ, CH_BS, CH_DQ, CH_NL, 8'h0C, CH_SQ, CH_DQ, CH_BS, CH_DQ,
                      CH_NL, CH_SQ, CH_DQ, 8'h0D, CH_BS, CH_NL, CH_BS, CH_SQ, 8'h0D, CH_NL};
    gap_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    for (int n = 0; n < RANDOM_BYTES; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 8;
          default: gap_pct = 30;
        endcase
      end
      if (bytes_sent >= CALM_AT) calm = 1'b1;
      if (!calm && $urandom_range(99) < gap_pct) idle_input($urandom_range(1, 14));
      send_byte(pick_byte());
    end
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("quoted_word_line_tokenizer test passed");
    end else begin
      $display("quoted_word_line_tokenizer test failed");
    end
    $finish;
  end

  initial begin : drain
    int stall;
    int stall_pct;
    bit held;
    stall = 0;
    stall_pct = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (!held && bytes_sent >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm) begin
        if ($urandom_range(63) == 0) begin
          case ($urandom_range(2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 35;
          endcase
        end
        if ($urandom_range(99) < stall_pct) stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("quoted_word_line_tokenizer test failed");
      $finish;
    end
  end

endmodule

>>> files.f
src/qwlt_pkg.sv
src/quoted_word_line_tokenizer.sv
sim/tb_top.sv
